>>> hw/rtl/apss_pkg.sv
// Package for the amplitude polarization square-sum unit.
// Shared constants, codes and the datapath control struct; no dependencies.
package apss_pkg;

    localparam int MAX_OUTER_DEF = 256;
    localparam int LAMBDA_SIZE   = 3;
    localparam int POL_COUNT     = 7;
    localparam int ELEM_W        = 32;
    localparam int SUM_W         = 64;
    localparam int UOP_W         = 6;
    localparam logic [UOP_W-1:0] UOP_LAST = 6'd33;

    localparam logic [1:0] OP_LOAD_LEFT  = 2'd0;
    localparam logic [1:0] OP_LOAD_RIGHT = 2'd1;
    localparam logic [1:0] OP_COMPUTE    = 2'd2;

    localparam logic [1:0] REG_LHS_COUNT = 2'd0;
    localparam logic [1:0] REG_RHS_COUNT = 2'd1;
    localparam logic [1:0] REG_POL_MASK  = 2'd2;

    typedef struct packed {
        logic             clear;
        logic             load;
        logic [1:0]       lane;
        logic             step;
        logic             phase;
        logic [UOP_W-1:0] uop;
        logic [2:0]       sel;
    } ctrl_t;

endpackage

>>> hw/rtl/apss_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
module apss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/apss_mac.sv
// Shared multiply-accumulate datapath: operand registers, one 32x32 multiplier,
// term accumulator, intermediate terms and seven saturating sums. Uses apss_pkg.
module apss_mac (
    input  logic                     clk,
    input  logic                     rst_n,
    input  apss_pkg::ctrl_t          ctrl,
    input  logic [apss_pkg::ELEM_W-1:0] left_data,
    input  logic [apss_pkg::ELEM_W-1:0] right_data,
    output logic [apss_pkg::SUM_W-1:0]  sum
);

    localparam logic [3:0] D_NONE = 4'd0;
    localparam logic [3:0] D_PR   = 4'd1;
    localparam logic [3:0] D_PI   = 4'd2;
    localparam logic [3:0] D_LR   = 4'd3;
    localparam logic [3:0] D_LI   = 4'd4;
    localparam logic [3:0] D_RR   = 4'd5;
    localparam logic [3:0] D_RI   = 4'd6;
    localparam logic [3:0] D_MAG  = 4'd7;
    localparam logic [3:0] D_INT  = 4'd8;

    logic signed [15:0] ar_reg [3];
    logic signed [15:0] ai_reg [3];
    logic signed [15:0] br_reg [3];
    logic signed [15:0] bi_reg [3];
    logic signed [33:0] pr_reg [3];
    logic signed [33:0] pi_reg [3];
    logic signed [31:0] lr_reg, li_reg, rr_reg, ri_reg;
    logic signed [63:0] prod_reg;
    logic signed [65:0] tmp_reg;
    logic signed [63:0] acc_reg [7];

    logic signed [16:0] xrl, xil, yrl, yil, xrr, xir, yrr, yir;
    logic signed [31:0] ur, ui, t2r, t2i, tr, ti, sr, si;
    logic signed [31:0] x, y;
    logic               neg, first;
    logic [3:0]         dest;
    logic [1:0]         lane;
    logic [2:0]         acc_idx;
    logic signed [65:0] v;
    logic signed [63:0] term;
    logic signed [64:0] s;

    function automatic logic signed [31:0] rnd4(input logic signed [35:0] a);
        logic signed [35:0] t;
        t = (a + 36'sd8) >>> 4;
        return t[31:0];
    endfunction

    assign xrl = 17'(ar_reg[0]) - 17'(ai_reg[1]);
    assign xil = 17'(ai_reg[0]) + 17'(ar_reg[1]);
    assign yrl = 17'(br_reg[0]) + 17'(bi_reg[1]);
    assign yil = 17'(bi_reg[0]) - 17'(br_reg[1]);
    assign xrr = 17'(ar_reg[0]) + 17'(ai_reg[1]);
    assign xir = 17'(ai_reg[0]) - 17'(ar_reg[1]);
    assign yrr = 17'(br_reg[0]) - 17'(bi_reg[1]);
    assign yir = 17'(bi_reg[0]) + 17'(br_reg[1]);

    assign ur  = rnd4(36'(pr_reg[0]) + 36'(pr_reg[1]) + 36'(pr_reg[2]));
    assign ui  = rnd4(36'(pi_reg[0]) + 36'(pi_reg[1]) + 36'(pi_reg[2]));
    assign t2r = rnd4(36'(pr_reg[2]));
    assign t2i = rnd4(36'(pi_reg[2]));
    assign tr  = rnd4(36'(pr_reg[0]) + 36'(pr_reg[1]));
    assign ti  = rnd4(36'(pi_reg[0]) + 36'(pi_reg[1]));
    assign sr  = rnd4(36'(pr_reg[0])) + rnd4(36'(pr_reg[1]));
    assign si  = rnd4(36'(pi_reg[0])) + rnd4(36'(pi_reg[1]));

    // micro-op table: products of one (k,j) pair, then the seven terms
    always_comb
    begin
        x       = '0;
        y       = '0;
        neg     = 1'b0;
        first   = 1'b0;
        dest    = D_NONE;
        lane    = 2'(ctrl.uop[3:2]);
        acc_idx = '0;
        if (ctrl.uop < 6'd12)
        begin
            unique case (ctrl.uop[1:0])
                2'd0:
                begin
                    x = 32'(ar_reg[lane]); y = 32'(br_reg[lane]); first = 1'b1;
                end
                2'd1:
                begin
                    x = 32'(ai_reg[lane]); y = 32'(bi_reg[lane]); neg = 1'b1; dest = D_PR;
                end
                2'd2:
                begin
                    x = 32'(ar_reg[lane]); y = 32'(bi_reg[lane]); first = 1'b1;
                end
                default:
                begin
                    x = 32'(ai_reg[lane]); y = 32'(br_reg[lane]); dest = D_PI;
                end
            endcase
        end
        else
        begin
            unique case (ctrl.uop)
                6'd12: begin x = 32'(xrl); y = 32'(yrl); first = 1'b1; end
                6'd13: begin x = 32'(xil); y = 32'(yil); neg = 1'b1; dest = D_LR; end
                6'd14: begin x = 32'(xrl); y = 32'(yil); first = 1'b1; end
                6'd15: begin x = 32'(xil); y = 32'(yrl); dest = D_LI; end
                6'd16: begin x = 32'(xrr); y = 32'(yrr); first = 1'b1; end
                6'd17: begin x = 32'(xir); y = 32'(yir); neg = 1'b1; dest = D_RR; end
                6'd18: begin x = 32'(xrr); y = 32'(yir); first = 1'b1; end
                6'd19: begin x = 32'(xir); y = 32'(yrr); dest = D_RI; end
                6'd20: begin x = ur; y = ur; first = 1'b1; end
                6'd21: begin x = ui; y = ui; dest = D_MAG; acc_idx = 3'd0; end
                6'd22: begin x = t2r; y = t2r; first = 1'b1; end
                6'd23: begin x = t2i; y = t2i; dest = D_MAG; acc_idx = 3'd1; end
                6'd24: begin x = tr; y = tr; first = 1'b1; end
                6'd25: begin x = ti; y = ti; dest = D_MAG; acc_idx = 3'd2; end
                6'd26: begin x = lr_reg; y = lr_reg; first = 1'b1; end
                6'd27: begin x = li_reg; y = li_reg; dest = D_MAG; acc_idx = 3'd3; end
                6'd28: begin x = rr_reg; y = rr_reg; first = 1'b1; end
                6'd29: begin x = ri_reg; y = ri_reg; dest = D_MAG; acc_idx = 3'd4; end
                6'd30: begin x = sr; y = t2r; first = 1'b1; end
                6'd31: begin x = si; y = t2i; dest = D_INT; acc_idx = 3'd5; end
                6'd32: begin x = lr_reg; y = rr_reg; first = 1'b1; end
                6'd33: begin x = li_reg; y = ri_reg; dest = D_INT; acc_idx = 3'd6; end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        v = (first ? 66'sd0 : tmp_reg) + (neg ? -66'(prod_reg) : 66'(prod_reg));
        if (dest == D_MAG)
        begin
            term = 64'((v + 66'sd32768) >>> 16);
        end
        else
        begin
            term = 64'((v + 66'sd16384) >>> 15);
        end
        s = 65'(acc_reg[acc_idx]) + 65'(term);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            ar_reg[ctrl.lane] <= left_data[15:0];
            ai_reg[ctrl.lane] <= left_data[31:16];
            br_reg[ctrl.lane] <= right_data[15:0];
            bi_reg[ctrl.lane] <= right_data[31:16];
        end
        if (ctrl.step && !ctrl.phase)
        begin
            prod_reg <= x * y;
        end
        if (ctrl.step && ctrl.phase)
        begin
            tmp_reg <= v;
            unique case (dest)
                D_PR: pr_reg[lane] <= v[33:0];
                D_PI: pi_reg[lane] <= v[33:0];
                D_LR: lr_reg <= 32'((v + 66'sd16) >>> 5);
                D_LI: li_reg <= 32'((v + 66'sd16) >>> 5);
                D_RR: rr_reg <= 32'((v + 66'sd16) >>> 5);
                D_RI: ri_reg <= 32'((v + 66'sd16) >>> 5);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 7; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else if (ctrl.clear)
        begin
            for (int i = 0; i < 7; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else if (ctrl.step && ctrl.phase && (dest == D_MAG || dest == D_INT))
        begin
            if (s[64] != s[63])
            begin
                acc_reg[acc_idx] <= s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            end
            else
            begin
                acc_reg[acc_idx] <= s[63:0];
            end
        end
    end

    assign sum = acc_reg[ctrl.sel];

endmodule

>>> hw/rtl/amplitude_polarization_square_sum_unit.sv
// Top level of the amplitude polarization square-sum unit: APB registers,
// stream ports, sequencer and tensor stores. Uses apss_pkg, apss_ram, apss_mac.
//
//  channel | dir | contents
//  s_*     | in  | tuser: opcode; tdata: element_address, value_real, value_imag
//  m_*     | out | tuser: polarization_code, error_flag; tdata: sum_value; tlast
//  APB     | in  | lhs_outer_count @0x0, rhs_outer_count @0x4, polarization_mask @0x8
//
// Loads write the store on their transfer. For each (k,j) pair of a compute, the
// fetch state reads the stores, then 34 products pass through the one shared
// multiplier, each in a multiply and an accumulate phase; then the emit state visits
// every mask bit, set or not. An empty mask gives its error result through the error
// state. s_tready is low during a compute. Results wait in the output register under
// m_tready backpressure. Reset clears control and sums; the stores are not cleared.
module amplitude_polarization_square_sum_unit #(
    parameter int MAX_OUTER = apss_pkg::MAX_OUTER_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // element_address[9:0], value_real[25:10], value_imag[41:26]
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // sum_value[63:0]
    output logic [3:0]  m_tuser,   // polarization_code[2:0], error_flag[3]
    output logic        m_tlast
);

    localparam int DEPTH = MAX_OUTER * apss_pkg::LAMBDA_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_OUTER + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_MAC   = 3'd2;
    localparam logic [2:0] S_EMIT  = 3'd3;
    localparam logic [2:0] S_ERR   = 3'd4;

    logic [8:0] lhs_reg, rhs_reg;
    logic [6:0] mask_reg;
    logic [2:0] state_reg, state_next;
    logic [CW-1:0] k_reg, k_next, j_reg, j_next, nk, nj;
    logic [1:0] f_reg, f_next;
    logic [apss_pkg::UOP_W-1:0] uop_reg, uop_next;
    logic phase_reg, phase_next;
    logic [2:0] p_reg, p_next;
    logic ov_reg, ov_next;
    logic [63:0] osum_reg, osum_next;
    logic [2:0] ocode_reg, ocode_next;
    logic oerr_reg, oerr_next, olast_reg, olast_next;

    logic cfg_wr, in_acc, ofree, we_l, we_r, in_range;
    logic [AW-1:0] waddr, raddr_l, raddr_r;
    logic [31:0] ldata, rdata;
    logic [63:0] sum;
    apss_pkg::ctrl_t ctrl;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign ofree    = !ov_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lhs_reg  <= 9'd1;
            rhs_reg  <= 9'd1;
            mask_reg <= 7'd1;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                apss_pkg::REG_LHS_COUNT: lhs_reg  <= pwdata[8:0];
                apss_pkg::REG_RHS_COUNT: rhs_reg  <= pwdata[8:0];
                apss_pkg::REG_POL_MASK:  mask_reg <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            apss_pkg::REG_LHS_COUNT: prdata = 32'(lhs_reg);
            apss_pkg::REG_RHS_COUNT: prdata = 32'(rhs_reg);
            apss_pkg::REG_POL_MASK:  prdata = 32'(mask_reg);
            default:                 prdata = '0;
        endcase
    end

    always_comb
    begin
        if (lhs_reg == 9'd0)
            nk = CW'(1);
        else if (32'(lhs_reg) > MAX_OUTER)
            nk = CW'(MAX_OUTER);
        else
            nk = CW'(lhs_reg);
        if (rhs_reg == 9'd0)
            nj = CW'(1);
        else if (32'(rhs_reg) > MAX_OUTER)
            nj = CW'(MAX_OUTER);
        else
            nj = CW'(rhs_reg);
    end

    // stores
    assign in_range = 32'(s_tdata[9:0]) < DEPTH;
    assign waddr    = AW'(s_tdata[9:0]);
    assign we_l     = in_acc && in_range && (s_tuser == apss_pkg::OP_LOAD_LEFT);
    assign we_r     = in_acc && in_range && (s_tuser == apss_pkg::OP_LOAD_RIGHT);

    always_comb
    begin
        unique case (f_reg)
            2'd0:    raddr_l = AW'(k_reg);
            2'd1:    raddr_l = AW'(k_reg) + AW'(nk);
            default: raddr_l = AW'(k_reg) + (AW'(nk) << 1);
        endcase
        raddr_r = (AW'(j_reg) << 1) + AW'(j_reg) + AW'(f_reg);
    end

    apss_ram #(.WIDTH(apss_pkg::ELEM_W), .DEPTH(DEPTH)) u_left (
        .clk(clk), .we(we_l), .waddr(waddr), .wdata(s_tdata[41:10]),
        .raddr(raddr_l), .rdata(ldata)
    );

    apss_ram #(.WIDTH(apss_pkg::ELEM_W), .DEPTH(DEPTH)) u_right (
        .clk(clk), .we(we_r), .waddr(waddr), .wdata(s_tdata[41:10]),
        .raddr(raddr_r), .rdata(rdata)
    );

    always_comb
    begin
        ctrl.clear = in_acc && (s_tuser == apss_pkg::OP_COMPUTE);
        ctrl.load  = (state_reg == S_FETCH) && (f_reg != 2'd0);
        ctrl.lane  = f_reg - 2'd1;
        ctrl.step  = (state_reg == S_MAC);
        ctrl.phase = phase_reg;
        ctrl.uop   = uop_reg;
        ctrl.sel   = p_reg;
    end

    apss_mac u_mac (
        .clk(clk), .rst_n(rst_n), .ctrl(ctrl),
        .left_data(ldata), .right_data(rdata), .sum(sum)
    );

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        j_next     = j_reg;
        f_next     = f_reg;
        uop_next   = uop_reg;
        phase_next = phase_reg;
        p_next     = p_reg;
        ov_next    = ov_reg && !m_tready;
        osum_next  = osum_reg;
        ocode_next = ocode_reg;
        oerr_next  = oerr_reg;
        olast_next = olast_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && s_tuser == apss_pkg::OP_COMPUTE)
                begin
                    k_next = '0;
                    j_next = '0;
                    f_next = '0;
                    p_next = '0;
                    state_next = (mask_reg == 7'd0) ? S_ERR : S_FETCH;
                end
            end
            S_FETCH:
            begin
                f_next = f_reg + 2'd1;
                if (f_reg == 2'd3)
                begin
                    uop_next   = '0;
                    phase_next = 1'b0;
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                phase_next = !phase_reg;
                if (phase_reg)
                begin
                    uop_next = uop_reg + 1'b1;
                    if (uop_reg == apss_pkg::UOP_LAST)
                    begin
                        f_next = '0;
                        state_next = S_FETCH;
                        if (j_reg == nj - 1'b1)
                        begin
                            j_next = '0;
                            k_next = k_reg + 1'b1;
                            if (k_reg == nk - 1'b1)
                                state_next = S_EMIT;
                        end
                        else
                        begin
                            j_next = j_reg + 1'b1;
                        end
                    end
                end
            end
            S_EMIT:
            begin
                if (!mask_reg[p_reg] || ofree)
                begin
                    if (mask_reg[p_reg])
                    begin
                        ov_next    = 1'b1;
                        osum_next  = sum;
                        ocode_next = p_reg;
                        oerr_next  = 1'b0;
                        olast_next = (7'(mask_reg >> p_reg) >> 1) == 7'd0;
                    end
                    p_next = p_reg + 3'd1;
                    if (p_reg == 3'(apss_pkg::POL_COUNT - 1))
                        state_next = S_IDLE;
                end
            end
            S_ERR:
            begin
                if (ofree)
                begin
                    ov_next    = 1'b1;
                    osum_next  = '0;
                    ocode_next = '0;
                    oerr_next  = 1'b1;
                    olast_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            j_reg     <= '0;
            f_reg     <= '0;
            uop_reg   <= '0;
            phase_reg <= 1'b0;
            p_reg     <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            j_reg     <= j_next;
            f_reg     <= f_next;
            uop_reg   <= uop_next;
            phase_reg <= phase_next;
            p_reg     <= p_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        osum_reg  <= osum_next;
        ocode_reg <= ocode_next;
        oerr_reg  <= oerr_next;
        olast_reg <= olast_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = osum_reg;
    assign m_tuser  = {oerr_reg, ocode_reg};
    assign m_tlast  = olast_reg;

endmodule
